// ===== rtl/utf8_to_codepoint_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// UTF-8 decoder assertion macros
// Concurrent assertion wrappers clocked on clock, with an optional reset gate.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_CODEPOINT_DECODER_MACROS_SVH
`define UTF8_TO_CODEPOINT_DECODER_MACROS_SVH

`ifndef ASSERT_OFF

// check prop on every clock edge, idle while reset is high
`define U8CD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check prop on every clock edge, reset included
`define U8CD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`else

`define U8CD_ASSERT(lbl, prop, msg)

`define U8CD_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== rtl/u8cd_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared widths, the replacement codepoint, the lead length table and the
// result of one decode step.
// ----------------------------------------------------------------------------
package u8cd_pkg;

   localparam int BYTE_W    = 8;
   localparam int WIN_BYTES = 4;
   localparam int WIN_W     = BYTE_W * WIN_BYTES;
   localparam int CNT_W     = 3;
   localparam int LEN_W     = 3;
   localparam int CP_W      = 21;

   localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

   typedef struct packed {
      logic             emit;
      logic             replaced;
      logic             last;
      logic [CNT_W-1:0] consume;
      logic [CP_W-1:0]  codepoint;
      logic [WIN_W-1:0] next_win;
   } u8cd_step_type;

   // sequence length from the high nibble of a lead byte; 0 = not a lead
   function automatic logic [LEN_W-1:0] lead_len(input logic [3:0] nibble);
      logic [LEN_W-1:0] len;
      unique case (nibble)
         4'h0, 4'h1, 4'h2, 4'h3,
         4'h4, 4'h5, 4'h6, 4'h7: len = 3'd1;
         4'h8, 4'h9, 4'hA, 4'hB: len = 3'd0;
         4'hC, 4'hD:             len = 3'd2;
         4'hE:                   len = 3'd3;
         default:                len = 3'd4;
      endcase
      return len;
   endfunction

endpackage

// ===== rtl/u8cd_seq_check.sv =====
// ----------------------------------------------------------------------------
// UTF-8 sequence check
// Looks at the sequence starting at the head of the byte window, validates
// it and gives one result, how many bytes it consumes and the window after.
// ----------------------------------------------------------------------------
module u8cd_seq_check (
   input  logic [u8cd_pkg::WIN_W-1:0] win,
   input  logic [u8cd_pkg::CNT_W-1:0] avail,
   input  logic                       eot,
   output u8cd_pkg::u8cd_step_type    step
);
   import u8cd_pkg::*;

   logic [BYTE_W-1:0] b0, b1, b2, b3;
   logic [LEN_W-1:0]  len;
   logic [LEN_W-1:0]  next_len;
   logic              cont1, cont2, cont3;
   logic              ok;
   logic [CP_W-1:0]   cp;
   logic              emit;
   logic              replaced;
   logic              last;
   logic [CNT_W-1:0]  consume;
   logic [CP_W-1:0]   codepoint;
   logic [CNT_W-1:0]  rem;
   logic [WIN_W-1:0]  shifted;

   assign b0 = win[0*BYTE_W +: BYTE_W];
   assign b1 = win[1*BYTE_W +: BYTE_W];
   assign b2 = win[2*BYTE_W +: BYTE_W];
   assign b3 = win[3*BYTE_W +: BYTE_W];

   assign len   = lead_len(b0[7:4]);
   assign cont1 = (b1[7:6] == 2'b10);
   assign cont2 = (b2[7:6] == 2'b10);
   assign cont3 = (b3[7:6] == 2'b10);

   // marker, overlong and surrogate checks per length
   always_comb begin
      ok = 1'b0;
      cp = '0;
      unique case (len)
         3'd1: begin
            ok = 1'b1;
            cp = {14'd0, b0[6:0]};
         end
         3'd2: begin
            ok = (b0[7:5] == 3'b110) && cont1 && (b0[4:1] != 4'd0);
            cp = {10'd0, b0[4:0], b1[5:0]};
         end
         3'd3: begin
            ok = (b0[7:4] == 4'hE) && cont1 && cont2
                 && ((b0[3:0] != 4'd0) || b1[5])
                 && !((b0 == 8'hED) && (b1[7:5] == 3'b101));
            cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
         end
         3'd4: begin
            ok = (b0[7:3] == 5'b11110) && cont1 && cont2 && cont3
                 && ((b0[2:0] != 3'd0) || (b1[5:4] != 2'd0));
            cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
         end
         default: begin
            ok = 1'b0;
            cp = '0;
         end
      endcase
   end

   always_comb begin
      emit      = 1'b1;
      replaced  = 1'b1;
      consume   = 3'd1;
      codepoint = REPLACEMENT_CP;
      priority if (len == 3'd0) begin
         emit = 1'b1;
      end else if (len > avail) begin
         // hold an unfinished sequence unless the text ends here
         emit = eot;
      end else if (ok) begin
         replaced  = 1'b0;
         consume   = len;
         codepoint = cp;
      end else begin
         replaced = 1'b1;
      end
   end

   assign shifted  = win >> {consume, 3'b000};
   assign rem      = avail - consume;
   assign next_len = lead_len(shifted[7:4]);

   // last when nothing is left, or what is left waits for more bytes
   assign last = (rem == 3'd0)
                 || (!eot && (next_len != 3'd0) && (next_len > rem));

   // fields in the order of the step type
   assign step = {emit, replaced, last, consume, codepoint, shifted};

endmodule

// ===== rtl/utf8_to_codepoint_decoder.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to codepoint decoder
// Takes one UTF-8 byte per word and gives one codepoint word per decoded
// character, U+FFFD flagged as replaced for a bad or truncated sequence, in
// which case only the first byte is dropped and the rest is scanned again.
// Lead bytes F5-F7 and codepoints up to 0x1FFFFF pass. Each byte is taken in
// and then scanned once per result it causes, and at least once: a single
// sequence check unit decodes the head of a four-byte window and gives one
// result a cycle while the result side does not stall, and req_stall stays
// high while the window is being scanned. The last result of a byte carries
// rsp_run_last; a byte that only extends an unfinished sequence gives no
// result.
// ----------------------------------------------------------------------------
`include "utf8_to_codepoint_decoder_macros.svh"

module utf8_to_codepoint_decoder (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [u8cd_pkg::BYTE_W-1:0] req_in_byte,
   input  logic                        req_end_of_text,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [u8cd_pkg::CP_W-1:0]   rsp_codepoint,
   output logic                        rsp_replaced,
   output logic                        rsp_run_last
);
   import u8cd_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic             state_ff, state_in;
   logic [WIN_W-1:0] win_ff, win_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             eot_ff, eot_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CP_W-1:0]  rsp_codepoint_ff, rsp_codepoint_in;
   logic             rsp_replaced_ff, rsp_replaced_in;
   logic             rsp_run_last_ff, rsp_run_last_in;
   logic             out_free;
   u8cd_step_type    step;

   u8cd_seq_check u_seq_check (
      .win   (win_ff),
      .avail (cnt_ff),
      .eot   (eot_ff),
      .step  (step)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in         = state_ff;
      win_in           = win_ff;
      cnt_in           = cnt_ff;
      eot_in           = eot_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_codepoint_in = rsp_codepoint_ff;
      rsp_replaced_in  = rsp_replaced_ff;
      rsp_run_last_in  = rsp_run_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // append the new byte behind the pending ones
               win_in[{cnt_ff[1:0], 3'b000} +: BYTE_W] = req_in_byte;
               cnt_in   = cnt_ff + 3'd1;
               eot_in   = req_end_of_text;
               state_in = ST_SCAN;
            end
         end
         default: begin
            if (out_free) begin
               if (step.emit) begin
                  rsp_valid_in     = 1'b1;
                  rsp_codepoint_in = step.codepoint;
                  rsp_replaced_in  = step.replaced;
                  rsp_run_last_in  = step.last;
                  win_in           = step.next_win;
                  cnt_in           = cnt_ff - step.consume;
                  if (step.last) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         eot_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         eot_ff       <= eot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff           <= win_in;
      rsp_codepoint_ff <= rsp_codepoint_in;
      rsp_replaced_ff  <= rsp_replaced_in;
      rsp_run_last_ff  <= rsp_run_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_codepoint = rsp_codepoint_ff;
   assign rsp_replaced  = rsp_replaced_ff;
   assign rsp_run_last  = rsp_run_last_ff;

   `U8CD_ASSERT(a_idle_cnt_fits, (state_ff == ST_IDLE) |-> (cnt_ff <= 3'd3), "pending overflow")
   `U8CD_ASSERT(a_eot_drains, (state_ff == ST_SCAN && state_in == ST_IDLE && eot_ff) |=> (cnt_ff == 3'd0), "buffer not empty after end of text")
   `U8CD_ASSERT(a_replaced_cp, (rsp_valid && rsp_replaced) |-> (rsp_codepoint == REPLACEMENT_CP), "replaced word without U+FFFD")
   `U8CD_ASSERT(a_load_in_scan, $rose(rsp_valid) |-> $past(state_ff == ST_SCAN), "result loaded outside scan")

endmodule

// ===== tb/utf8_codepoint_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder codepoint checker
// Watches the byte and codepoint channels of the decoder, decodes every byte
// taken with its own copy of the pending-byte window, and compares each
// codepoint word given out, field by field, with the oldest one predicted.
// ----------------------------------------------------------------------------
module utf8_codepoint_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [u8cd_pkg::BYTE_W-1:0] req_in_byte,
   input  logic                        req_end_of_text,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [u8cd_pkg::CP_W-1:0]   rsp_codepoint,
   input  logic                        rsp_replaced,
   input  logic                        rsp_run_last,
   output int                          error_count,
   output int                          results_due,
   output int                          bytes_taken,
   output int                          words_checked,
   output int                          replaced_words
);

   localparam int MAX_WORDS_PER_BYTE = 4;

   typedef struct packed {
      logic [u8cd_pkg::CP_W-1:0] codepoint;
      logic                      replaced;
      logic                      run_last;
   } codepoint_word_type;

   codepoint_word_type pending_codepoints[$];
   logic [2:0][7:0]    held_bytes;
   int unsigned        held_count = 0;
   int                 mismatches = 0;

   // bytes in the sequence started by this lead; 0 for a continuation byte
   function automatic int unsigned seq_length(input logic [7:0] lead);
      if (lead < 8'h80)
         return 1;
      else if (lead < 8'hC0)
         return 0;
      else if (lead < 8'hE0)
         return 2;
      else if (lead < 8'hF0)
         return 3;
      return 4;
   endfunction

   function automatic bit decode_char(input logic [3:0][7:0] win, input int unsigned pos,
                                      input int unsigned len,
                                      output logic [u8cd_pkg::CP_W-1:0] cp);
      logic [31:0] enc;
      bit          good;
      enc  = '0;
      good = 1'b1;
      cp   = '0;
      for (int i = 0; i < len; i++) begin
         if (i > 0 && win[pos + i] == 8'h00)
            good = 1'b0;
         enc = {enc[23:0], win[pos + i]};
      end
      // marker bits, then the overlong check on the payload's top bits
      case (len)
         1: if (enc[7])
               good = 1'b0;
         2: if ((enc & 32'hE0C0) != 32'hC080 || (enc & 32'h1E00) == 0)
               good = 1'b0;
         3: if ((enc & 32'hF0C0C0) != 32'hE08080 || (enc & 32'h0F2000) == 0)
               good = 1'b0;
         default: if ((enc & 32'hF8C0C0C0) != 32'hF0808080 || (enc & 32'h07300000) == 0)
               good = 1'b0;
      endcase
      // surrogate range D800-DFFF
      if ((enc & 32'hFFE0C0) == 32'hEDA080)
         good = 1'b0;
      case (len)
         1:       cp = {14'd0, enc[6:0]};
         2:       cp = {10'd0, enc[12:8], enc[5:0]};
         3:       cp = {5'd0, enc[19:16], enc[13:8], enc[5:0]};
         default: cp = {enc[26:24], enc[21:16], enc[13:8], enc[5:0]};
      endcase
      return good;
   endfunction

   function automatic void decode_byte(input logic [7:0] b, input logic eot);
      logic [3:0][7:0]           win;
      logic [u8cd_pkg::CP_W-1:0] cp;
      int unsigned               n;
      int unsigned               pos;
      int unsigned               cnt;
      int unsigned               len;
      bit                        good;
      codepoint_word_type        w;
      win = '0;
      for (int i = 0; i < 3; i++)
         if (i < held_count)
            win[i] = held_bytes[i];
      win[held_count] = b;
      n   = held_count + 1;
      pos = 0;
      cnt = 0;
      while (pos < n && cnt < MAX_WORDS_PER_BYTE) begin
         len  = seq_length(win[pos]);
         good = 1'b0;
         // hold an unfinished sequence unless the text ends here
         if (len > n - pos && !eot)
            break;
         if (len != 0 && len <= n - pos)
            good = decode_char(win, pos, len, cp);
         w.codepoint = good ? cp : u8cd_pkg::REPLACEMENT_CP;
         w.replaced  = !good;
         w.run_last  = 1'b0;
         pos += good ? len : 1;
         pending_codepoints.push_back(w);
         cnt++;
      end
      if (cnt > 0) begin
         w = pending_codepoints.pop_back();
         w.run_last = 1'b1;
         pending_codepoints.push_back(w);
      end
      held_count = 0;
      while (pos < n && held_count < 3) begin
         held_bytes[held_count] = win[pos];
         held_count++;
         pos++;
      end
   endfunction

   always @(posedge clock) begin : watch_channels
      codepoint_word_type want;
      if (reset) begin
         pending_codepoints.delete();
         held_count = 0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_byte(req_in_byte, req_end_of_text);
            bytes_taken <= bytes_taken + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            words_checked <= words_checked + 1;
            if (rsp_replaced)
               replaced_words <= replaced_words + 1;
            if (pending_codepoints.size() == 0) begin
               $error("codepoint word %06h with none predicted", rsp_codepoint);
               mismatches++;
            end else begin
               want = pending_codepoints.pop_front();
               if (rsp_codepoint !== want.codepoint) begin
                  $error("codepoint: expected %06h, got %06h", want.codepoint, rsp_codepoint);
                  mismatches++;
               end
               if (rsp_replaced !== want.replaced) begin
                  $error("replaced: expected %0b, got %0b", want.replaced, rsp_replaced);
                  mismatches++;
               end
               if (rsp_run_last !== want.run_last) begin
                  $error("run_last: expected %0b, got %0b", want.run_last, rsp_run_last);
                  mismatches++;
               end
            end
         end
      end
      error_count <= mismatches;
      results_due <= pending_codepoints.size();
   end

endmodule

// ===== tb/utf8_to_codepoint_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder testbench
// Feeds the decoder a directed set of edge-case bytes and then random text
// built mostly from well-formed characters, with overlong, broken and
// truncated sequences and noise mixed in, under four idle and stall
// phases. A separate checker predicts and compares the codepoint words.
// ----------------------------------------------------------------------------
module utf8_to_codepoint_decoder_tb;

   localparam int QUIET_LIMIT  = 2000;
   localparam int PHASE_BYTES  = 86;
   localparam int SETTLE_TICKS = 8;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic [u8cd_pkg::BYTE_W-1:0] req_in_byte;
   logic                        req_end_of_text;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [u8cd_pkg::CP_W-1:0]   rsp_codepoint;
   logic                        rsp_replaced;
   logic                        rsp_run_last;

   int          error_count;
   int          results_due;
   int          bytes_taken;
   int          words_checked;
   int          replaced_words;
   int unsigned idle_pct    = 0;
   int unsigned stall_pct   = 0;
   int unsigned quiet_ticks = 0;

   // {end_of_text, byte}
   logic [8:0] text_q[$];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   utf8_to_codepoint_decoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_codepoint   (rsp_codepoint),
      .rsp_replaced    (rsp_replaced),
      .rsp_run_last    (rsp_run_last)
   );

   utf8_codepoint_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_codepoint   (rsp_codepoint),
      .rsp_replaced    (rsp_replaced),
      .rsp_run_last    (rsp_run_last),
      .error_count     (error_count),
      .results_due     (results_due),
      .bytes_taken     (bytes_taken),
      .words_checked   (words_checked),
      .replaced_words  (replaced_words)
   );

   always @(posedge clock)
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_ticks <= 0;
      else
         quiet_ticks <= quiet_ticks + 1;
      if (quiet_ticks >= QUIET_LIMIT) begin
         $display("no word moved for %0d cycles", QUIET_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [3:0][7:0] utf8_bytes(input logic [20:0] cp,
                                                  input int unsigned len);
      logic [3:0][7:0] seq;
      seq = '0;
      case (len)
         1: seq[0] = {1'b0, cp[6:0]};
         2: begin
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = {2'b10, cp[5:0]};
         end
         3: begin
            seq[0] = {4'b1110, cp[15:12]};
            seq[1] = {2'b10, cp[11:6]};
            seq[2] = {2'b10, cp[5:0]};
         end
         default: begin
            seq[0] = {5'b11110, cp[20:18]};
            seq[1] = {2'b10, cp[17:12]};
            seq[2] = {2'b10, cp[11:6]};
            seq[3] = {2'b10, cp[5:0]};
         end
      endcase
      return seq;
   endfunction

   function automatic void mark_end_of_text();
      logic [8:0] item;
      item = text_q.pop_back();
      item[8] = 1'b1;
      text_q.push_back(item);
   endfunction

   function automatic void queue_random_text(input int unsigned want);
      logic [3:0][7:0] seq;
      logic [20:0]     cp;
      int unsigned     pick;
      int unsigned     len;
      int unsigned     keep;
      while (text_q.size() < want) begin
         pick = $urandom_range(99);
         len  = 0;
         cp   = '0;
         if (pick < 25) begin
            len = 1;
            cp  = 21'($urandom_range(8'h7F));
         end else if (pick < 45) begin
            len = 2;
            cp  = 21'($urandom_range(12'h7FF, 8'h80));
         end else if (pick < 62) begin
            len = 3;
            cp  = 21'($urandom_range(16'hFFFF, 12'h800));
         end else if (pick < 75) begin
            len = 4;
            cp  = 21'($urandom_range(21'h1FFFFF, 17'h10000));
         end else if (pick < 83) begin
            // overlong: a value that fits a shorter form
            len = $urandom_range(4, 2);
            cp  = 21'($urandom_range(len == 2 ? 8'h7F : len == 3 ? 12'h7FF : 16'hFFFF));
         end else if (pick < 92) begin
            len = $urandom_range(4, 2);
            cp  = 21'($urandom_range(21'h1FFFFF));
         end
         if (len == 0) begin
            text_q.push_back({1'b0, 8'($urandom_range(255))});
         end else begin
            seq  = utf8_bytes(cp, len);
            keep = len;
            // broken: cut short or spoil one continuation byte
            if (pick >= 83) begin
               if ($urandom_range(1))
                  keep = $urandom_range(len - 1, 1);
               else
                  seq[$urandom_range(len - 1, 1)] = 8'($urandom_range(255));
            end
            for (int i = 0; i < keep; i++)
               text_q.push_back({1'b0, seq[i]});
         end
         if ($urandom_range(11) == 0)
            mark_end_of_text();
      end
   endfunction

   task automatic send_word(input logic [8:0] item);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_in_byte     <= item[7:0];
      req_end_of_text <= item[8];
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // hold the sender until every predicted codepoint word has come out
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0)
         @(posedge clock);
   endtask

   task automatic run_phase(input int unsigned sender_idle, input int unsigned receiver_stall);
      text_q.delete();
      queue_random_text(PHASE_BYTES);
      mark_end_of_text();
      idle_pct = sender_idle;
      stall_pct <= receiver_stall;
      while (text_q.size() != 0)
         send_word(text_q.pop_front());
      wait_for_results();
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_in_byte     = '0;
      req_end_of_text = 1'b0;
      repeat (3)
         @(posedge clock);
      reset <= 1'b0;

      // ASCII ends, valid 2/3/4-byte forms up to 1FFFFF, overlong, surrogate,
      // F8 lead with a stray continuation, zero continuation, cut-off text
      text_q = {9'h000, 9'h07F, 9'h0C2, 9'h0A9, 9'h0C0, 9'h080, 9'h0E2, 9'h082,
                9'h0AC, 9'h0ED, 9'h0A0, 9'h080, 9'h0F0, 9'h09F, 9'h098, 9'h080,
                9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0F8, 9'h0BF, 9'h0C3, 9'h000,
                9'h0E2, 9'h182};
      while (text_q.size() != 0)
         send_word(text_q.pop_front());
      wait_for_results();

      run_phase(0, 0);
      run_phase(78, 0);
      run_phase(0, 78);
      run_phase(17, 17);

      repeat (SETTLE_TICKS)
         @(posedge clock);
      $display("Decoded %0d bytes into %0d codepoint words, %0d replaced,",
               bytes_taken, words_checked, replaced_words);
      $display("over directed edge cases and four sender/receiver idle mixes.");
      if (error_count == 0 && results_due == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
